// ===== rtl/ptom_pkg.sv =====
// ============================================================================
// ptom_pkg: shared types and codes of the order matcher
// Command and result codes, channel payloads, and the command and status
// groups that join the controller to the datapath.
// ============================================================================
package ptom_pkg;

    localparam logic [1:0] CMD_LIMIT  = 2'd0;
    localparam logic [1:0] CMD_MARKET = 2'd1;
    localparam logic [1:0] CMD_CANCEL = 2'd2;
    localparam logic [1:0] CMD_NONE   = 2'd3;

    localparam logic [2:0] KIND_ACCEPTED    = 3'd0;
    localparam logic [2:0] KIND_FILL_PART   = 3'd1;
    localparam logic [2:0] KIND_FILL_DONE   = 3'd2;
    localparam logic [2:0] KIND_CANCEL_DONE = 3'd3;
    localparam logic [2:0] KIND_CANCEL_MISS = 3'd4;
    localparam logic [2:0] KIND_REST_DROP   = 3'd5;

    typedef struct packed {
        logic [1:0]  command;
        logic        side;
        logic [31:0] order_id;
        logic [7:0]  price;
        logic [15:0] quantity;
    } t_order;

    typedef struct packed {
        logic [2:0]  kind;
        logic [31:0] taker_id;
        logic [31:0] maker_id;
        logic [7:0]  trade_price;
        logic [15:0] fill_qty;
        logic [15:0] left_qty;
        logic [7:0]  best_bid;
        logic        bid_present;
        logic [7:0]  best_ask;
        logic        ask_present;
        logic        last;
    } t_result;

    typedef struct packed {
        logic       load;
        logic       scan_start;
        logic       set_res;
        logic [2:0] res_kind;
        logic       set_tops;
        logic       set_last;
        logic       last_val;
        logic       fill;
        logic       rest;
        logic       cancel_clear;
    } t_dp_cmd;

    typedef struct packed {
        logic is_none;
        logic is_cancel;
        logic scan_done;
        logic hit;
        logic can_fill;
        logic rest_need;
        logic free;
    } t_dp_sts;

endpackage

// ===== rtl/ptom_chan.sv =====
// ============================================================================
// ptom_chan: valid/ready channel
// One transfer moves when valid and ready are both high at a clock edge.
// ============================================================================
interface ptom_chan #(
    parameter type t_data = logic
);
    logic  valid;
    logic  ready;
    t_data data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

// ===== rtl/price_time_order_matcher_top.sv =====
// ============================================================================
// price_time_order_matcher_top: limit order book with price-time priority
// Single-instrument matcher for limit, market and cancel commands over a
// bounded slot store, reporting accepts, fills, cancels and drops.
// ============================================================================
//
//  Channel  Direction  Payload              Transfer when
//  i_ord    in         ptom_pkg::t_order    i_ord.valid && i_ord.ready
//  o_res    out        ptom_pkg::t_result   o_res.valid && o_res.ready
//
// Every book lookup is one pass over the slot store, one slot per cycle
// through the registered read port.
// A submit or cancel costs one pass, plus one pass per fill, plus one pass
// after a rest or a successful cancel, plus a step for a dropped remainder.
// Every command first takes the load and start steps; an unknown command
// takes only those and reports nothing.
// Reset is synchronous and active low; it empties the book and clears the
// arrival counter, with no clearing pass needed.
// A new command is taken only once all results of the previous one have
// transferred; a stalled o_res simply holds the machine in place.
//
module price_time_order_matcher_top #(
    parameter int ORDER_SLOTS = 32,
    parameter int PRICE_TICKS = 256
) (
    input logic     i_clk,
    input logic     i_rst_n,
    ptom_chan.sink   i_ord,
    ptom_chan.source o_res
);
    import ptom_pkg::*;

    // The controller and the datapath talk only through these groups.
    t_dp_cmd w_cmd;
    t_dp_sts w_sts;
    t_result w_res;
    logic    w_in_ready;
    logic    w_out_valid;

    ptom_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_ord.valid),
        .o_in_ready  (w_in_ready),
        .o_out_valid (w_out_valid),
        .i_out_ready (o_res.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd)
    );

    // The datapath owns the slot store, the scanner and the result register.
    ptom_dpath #(
        .ORDER_SLOTS (ORDER_SLOTS),
        .PRICE_TICKS (PRICE_TICKS)
    ) u_dpath (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_ord_data (i_ord.data),
        .i_cmd      (w_cmd),
        .o_sts      (w_sts),
        .o_res      (w_res)
    );

    assign i_ord.ready = w_in_ready;
    assign o_res.valid = w_out_valid;
    assign o_res.data  = w_res;

endmodule

// ===== rtl/ptom_dpath.sv =====
// ============================================================================
// ptom_dpath: order book datapath
// Slot store, sequential scanner for book tops, cancel hit and free slot,
// fill and rest arithmetic, and the pending result register.
// ============================================================================
module ptom_dpath #(
    parameter int ORDER_SLOTS = 32,
    parameter int PRICE_TICKS = 256
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  ptom_pkg::t_order  i_ord_data,
    input  ptom_pkg::t_dp_cmd i_cmd,
    output ptom_pkg::t_dp_sts o_sts,
    output ptom_pkg::t_result o_res
);
    import ptom_pkg::*;

    localparam int IW = $clog2(ORDER_SLOTS);
    localparam int CW = $clog2(ORDER_SLOTS + 1);
    localparam int PMAX = (PRICE_TICKS > 256) ? 255 : PRICE_TICKS - 1;
    localparam logic [7:0] PMAX8 = PMAX[7:0];
    localparam logic [CW-1:0] SCAN_END = CW'(ORDER_SLOTS);

    // Latched command.
    logic [1:0]  r_cmd;
    logic        r_side;
    logic [31:0] r_id;
    logic [7:0]  r_price;
    logic [15:0] r_qty;
    logic [31:0] r_cnt;

    // Slot store.
    logic [ORDER_SLOTS-1:0] r_used;
    logic                   m_side  [ORDER_SLOTS];
    logic [7:0]             m_price [ORDER_SLOTS];
    logic [31:0]            m_ident [ORDER_SLOTS];
    logic [15:0]            m_qty   [ORDER_SLOTS];
    logic [31:0]            m_stamp [ORDER_SLOTS];

    // Scanner.
    logic          r_scan_on;
    logic [CW-1:0] r_scan_idx;
    logic          r_rd_vld;
    logic          r_done;
    logic [IW-1:0] r_rd_idx;
    logic          r_rd_used;
    logic          r_rd_side;
    logic [7:0]    r_rd_price;
    logic [31:0]   r_rd_ident;
    logic [15:0]   r_rd_qty;
    logic [31:0]   r_rd_stamp;

    logic          r_bf    [2];
    logic [IW-1:0] r_bidx  [2];
    logic [7:0]    r_bprice[2];
    logic [31:0]   r_bage  [2];
    logic [31:0]   r_bident[2];
    logic [15:0]   r_bqty  [2];
    logic          r_hf;
    logic [IW-1:0] r_hidx;
    logic [31:0]   r_hage;
    logic          r_ff;
    logic [IW-1:0] r_fidx;

    t_result r_res;

    logic [IW-1:0] w_addr;
    logic [31:0]   w_age;
    logic [1:0]    w_take;
    logic          w_hit_take;
    logic          w_opp;
    logic [15:0]   w_mq;
    logic [15:0]   w_tq;
    logic [15:0]   w_nm;
    logic          w_cross;
    logic [7:0]    w_in_price;

    assign w_addr = r_scan_idx[IW-1:0];
    assign w_age  = r_cnt - r_rd_stamp;
    assign w_in_price = (i_ord_data.price > PMAX8) ? PMAX8 : i_ord_data.price;

    always_comb begin
        for (int s = 0; s < 2; s++) begin
            w_take[s] = 1'b0;
            if (r_rd_vld && r_rd_used && (r_rd_side == s[0])) begin
                if (!r_bf[s]) begin
                    w_take[s] = 1'b1;
                end else if (r_rd_price != r_bprice[s]) begin
                    w_take[s] = (s == 0) ? (r_rd_price > r_bprice[s])
                                         : (r_rd_price < r_bprice[s]);
                end else begin
                    w_take[s] = (w_age > r_bage[s]);
                end
            end
        end
    end

    assign w_hit_take = r_rd_vld && r_rd_used && (r_rd_ident == r_id) &&
                        (!r_hf || (w_age > r_hage));

    assign w_opp   = ~r_side;
    assign w_mq    = r_bqty[w_opp];
    assign w_tq    = (r_qty < w_mq) ? r_qty : w_mq;
    assign w_nm    = w_mq - w_tq;
    assign w_cross = (r_side == 1'b0) ? (r_bprice[w_opp] <= r_price)
                                      : (r_bprice[w_opp] >= r_price);

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_cmd   <= i_ord_data.command;
            r_side  <= i_ord_data.side;
            r_id    <= i_ord_data.order_id;
            r_price <= w_in_price;
            r_qty   <= i_ord_data.quantity;
        end else if (i_cmd.fill) begin
            r_qty <= r_qty - w_tq;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= '0;
            r_used <= '0;
        end else begin
            if (i_cmd.rest) begin
                r_cnt          <= r_cnt + 32'd1;
                r_used[r_fidx] <= 1'b1;
            end
            if (i_cmd.fill && (w_nm == 16'd0)) begin
                r_used[r_bidx[w_opp]] <= 1'b0;
            end
            if (i_cmd.cancel_clear) begin
                r_used[r_hidx] <= 1'b0;
            end
        end
    end

    // Store writes and registered scan reads.
    always_ff @(posedge i_clk) begin
        if (i_cmd.rest) begin
            m_side[r_fidx]  <= r_side;
            m_price[r_fidx] <= r_price;
            m_ident[r_fidx] <= r_id;
            m_qty[r_fidx]   <= r_qty;
            m_stamp[r_fidx] <= r_cnt;
        end else if (i_cmd.fill) begin
            m_qty[r_bidx[w_opp]] <= w_nm;
        end
        r_rd_idx   <= w_addr;
        r_rd_used  <= r_used[w_addr];
        r_rd_side  <= m_side[w_addr];
        r_rd_price <= m_price[w_addr];
        r_rd_ident <= m_ident[w_addr];
        r_rd_qty   <= m_qty[w_addr];
        r_rd_stamp <= m_stamp[w_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_on  <= 1'b0;
            r_scan_idx <= '0;
            r_rd_vld   <= 1'b0;
            r_done     <= 1'b0;
            r_bf[0]    <= 1'b0;
            r_bf[1]    <= 1'b0;
            r_hf       <= 1'b0;
            r_ff       <= 1'b0;
        end else begin
            r_rd_vld <= r_scan_on && (r_scan_idx != SCAN_END) && !i_cmd.scan_start;
            r_done   <= r_scan_on && (r_scan_idx == SCAN_END) && !i_cmd.scan_start;
            if (i_cmd.scan_start) begin
                r_scan_on  <= 1'b1;
                r_scan_idx <= '0;
                r_bf[0]    <= 1'b0;
                r_bf[1]    <= 1'b0;
                r_hf       <= 1'b0;
                r_ff       <= 1'b0;
            end else begin
                if (r_scan_on) begin
                    if (r_scan_idx == SCAN_END) begin
                        r_scan_on <= 1'b0;
                    end else begin
                        r_scan_idx <= r_scan_idx + 1'b1;
                    end
                end
                for (int s = 0; s < 2; s++) begin
                    if (w_take[s]) begin
                        r_bf[s] <= 1'b1;
                    end
                end
                if (w_hit_take) begin
                    r_hf <= 1'b1;
                end
                if (r_rd_vld && !r_rd_used && !r_ff) begin
                    r_ff <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int s = 0; s < 2; s++) begin
            if (w_take[s]) begin
                r_bidx[s]   <= r_rd_idx;
                r_bprice[s] <= r_rd_price;
                r_bage[s]   <= w_age;
                r_bident[s] <= r_rd_ident;
                r_bqty[s]   <= r_rd_qty;
            end
        end
        if (w_hit_take) begin
            r_hidx <= r_rd_idx;
            r_hage <= w_age;
        end
        if (r_rd_vld && !r_rd_used && !r_ff) begin
            r_fidx <= r_rd_idx;
        end
    end

    // Pending result.
    always_ff @(posedge i_clk) begin
        if (i_cmd.set_res) begin
            r_res.kind        <= i_cmd.res_kind;
            r_res.taker_id    <= r_id;
            r_res.maker_id    <= '0;
            r_res.trade_price <= '0;
            r_res.fill_qty    <= '0;
            r_res.left_qty    <= ((i_cmd.res_kind == KIND_ACCEPTED) ||
                                  (i_cmd.res_kind == KIND_REST_DROP)) ? r_qty : 16'd0;
        end
        if (i_cmd.fill) begin
            r_res.kind        <= (w_nm == 16'd0) ? KIND_FILL_DONE : KIND_FILL_PART;
            r_res.taker_id    <= r_id;
            r_res.maker_id    <= r_bident[w_opp];
            r_res.trade_price <= (r_cmd == CMD_LIMIT) ? r_price : r_bprice[w_opp];
            r_res.fill_qty    <= w_tq;
            r_res.left_qty    <= w_nm;
        end
        if (i_cmd.set_tops) begin
            r_res.best_bid    <= r_bf[0] ? r_bprice[0] : 8'd0;
            r_res.bid_present <= r_bf[0];
            r_res.best_ask    <= r_bf[1] ? r_bprice[1] : 8'd0;
            r_res.ask_present <= r_bf[1];
        end
        if (i_cmd.set_last) begin
            r_res.last <= i_cmd.last_val;
        end
    end

    assign o_res = r_res;

    assign o_sts.is_none   = (r_cmd == CMD_NONE);
    assign o_sts.is_cancel = (r_cmd == CMD_CANCEL);
    assign o_sts.scan_done = r_done;
    assign o_sts.hit       = r_hf;
    assign o_sts.can_fill  = (r_qty != 16'd0) && r_bf[w_opp] &&
                             ((r_cmd == CMD_MARKET) || w_cross);
    assign o_sts.rest_need = (r_cmd == CMD_LIMIT) && (r_qty != 16'd0);
    assign o_sts.free      = r_ff;

    a_fill_live: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.fill |-> (r_bf[w_opp] && r_used[r_bidx[w_opp]]))
        else $error("fill against a slot that is not a live best order");
    a_rest_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rest |-> (r_ff && !r_used[r_fidx]))
        else $error("rest into a slot that is in use");
    a_cancel_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.cancel_clear |-> (r_hf && r_used[r_hidx]))
        else $error("cancel clears a slot that was not found");
    a_done_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_done |=> !r_done)
        else $error("scan done held for more than one cycle");

endmodule

// ===== rtl/ptom_ctrl.sv =====
// ============================================================================
// ptom_ctrl: order matcher controller
// Sequences scans, fills, rests and result transfers for one command.
// ============================================================================
module ptom_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    input  ptom_pkg::t_dp_sts i_sts,
    output ptom_pkg::t_dp_cmd o_cmd
);
    import ptom_pkg::*;

    typedef enum logic [2:0] {
        S_IDLE, S_START, S_SCAN, S_EMIT, S_FILL, S_DROP
    } t_state;

    typedef enum logic [1:0] {
        P_FIRST, P_CANCEL, P_FILL, P_REST
    } t_phase;

    t_state  r_state, n_state, r_after, n_after;
    t_phase  r_phase, n_phase;
    logic    r_out_vld, n_out_vld;
    logic    w_decide;
    t_dp_cmd w_cmd;

    always_comb begin
        w_cmd     = '0;
        n_state   = r_state;
        n_after   = r_after;
        n_phase   = r_phase;
        n_out_vld = r_out_vld;
        w_decide  = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    n_state    = S_START;
                end
            end
            S_START: begin
                if (i_sts.is_none) begin
                    n_state = S_IDLE;
                end else begin
                    w_cmd.scan_start = 1'b1;
                    n_phase          = P_FIRST;
                    n_state          = S_SCAN;
                end
            end
            S_SCAN: begin
                if (i_sts.scan_done) begin
                    case (r_phase)
                        P_FIRST: begin
                            if (i_sts.is_cancel) begin
                                if (i_sts.hit) begin
                                    w_cmd.cancel_clear = 1'b1;
                                    w_cmd.scan_start   = 1'b1;
                                    n_phase            = P_CANCEL;
                                end else begin
                                    w_cmd.set_res  = 1'b1;
                                    w_cmd.res_kind = KIND_CANCEL_MISS;
                                    w_cmd.set_tops = 1'b1;
                                    w_cmd.set_last = 1'b1;
                                    w_cmd.last_val = 1'b1;
                                    n_out_vld      = 1'b1;
                                    n_after        = S_IDLE;
                                    n_state        = S_EMIT;
                                end
                            end else begin
                                w_cmd.set_res  = 1'b1;
                                w_cmd.res_kind = KIND_ACCEPTED;
                                w_cmd.set_tops = 1'b1;
                                w_decide       = 1'b1;
                            end
                        end
                        P_CANCEL: begin
                            w_cmd.set_res  = 1'b1;
                            w_cmd.res_kind = KIND_CANCEL_DONE;
                            w_cmd.set_tops = 1'b1;
                            w_cmd.set_last = 1'b1;
                            w_cmd.last_val = 1'b1;
                            n_out_vld      = 1'b1;
                            n_after        = S_IDLE;
                            n_state        = S_EMIT;
                        end
                        P_FILL: begin
                            w_cmd.set_tops = 1'b1;
                            w_decide       = 1'b1;
                        end
                        P_REST: begin
                            w_cmd.set_tops = 1'b1;
                            w_cmd.set_last = 1'b1;
                            w_cmd.last_val = 1'b1;
                            n_out_vld      = 1'b1;
                            n_after        = S_IDLE;
                            n_state        = S_EMIT;
                        end
                        default: n_state = S_IDLE;
                    endcase
                end
            end
            S_EMIT: begin
                if (i_out_ready) begin
                    n_out_vld = 1'b0;
                    n_state   = r_after;
                end
            end
            S_FILL: begin
                w_cmd.fill       = 1'b1;
                w_cmd.scan_start = 1'b1;
                n_phase          = P_FILL;
                n_state          = S_SCAN;
            end
            S_DROP: begin
                w_cmd.set_res  = 1'b1;
                w_cmd.res_kind = KIND_REST_DROP;
                w_cmd.set_last = 1'b1;
                w_cmd.last_val = 1'b1;
                n_out_vld      = 1'b1;
                n_after        = S_IDLE;
                n_state        = S_EMIT;
            end
            default: n_state = S_IDLE;
        endcase

        // After a submit or fill scan: trade on, rest, drop, or finish.
        if (w_decide) begin
            if (i_sts.can_fill) begin
                w_cmd.set_last = 1'b1;
                w_cmd.last_val = 1'b0;
                n_out_vld      = 1'b1;
                n_after        = S_FILL;
                n_state        = S_EMIT;
            end else if (i_sts.rest_need && i_sts.free) begin
                w_cmd.rest       = 1'b1;
                w_cmd.scan_start = 1'b1;
                n_phase          = P_REST;
                n_state          = S_SCAN;
            end else if (i_sts.rest_need) begin
                w_cmd.set_last = 1'b1;
                w_cmd.last_val = 1'b0;
                n_out_vld      = 1'b1;
                n_after        = S_DROP;
                n_state        = S_EMIT;
            end else begin
                w_cmd.set_last = 1'b1;
                w_cmd.last_val = 1'b1;
                n_out_vld      = 1'b1;
                n_after        = S_IDLE;
                n_state        = S_EMIT;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_after   <= S_IDLE;
            r_phase   <= P_FIRST;
            r_out_vld <= 1'b0;
        end else begin
            r_state   <= n_state;
            r_after   <= n_after;
            r_phase   <= n_phase;
            r_out_vld <= n_out_vld;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_vld;
    assign o_cmd       = w_cmd;

endmodule

// ===== tb/tb_top.sv =====
// ============================================================================
// tb_top: self-checking testbench of the price-time order matcher
// Drives limit, market and cancel commands through the order channel. A
// built-in order book model predicts every result. Each result transfer is
// compared field by field with the oldest prediction still waiting.
// ============================================================================
module tb_top;
    import ptom_pkg::*;

    localparam int SLOTS      = 32;
    localparam int WATCH_MAX  = 20000;

    logic i_clk;
    logic i_rst_n;

    ptom_chan #(.t_data(t_order))  ord_ch ();
    ptom_chan #(.t_data(t_result)) res_ch ();

    price_time_order_matcher_top dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ord   (ord_ch.sink),
        .o_res   (res_ch.source)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Book model: one entry per slot, kept the same way the block keeps it.
    logic        bk_used  [SLOTS];
    logic        bk_side  [SLOTS];
    logic [7:0]  bk_price [SLOTS];
    logic [31:0] bk_id    [SLOTS];
    logic [15:0] bk_qty   [SLOTS];
    logic [31:0] bk_stamp [SLOTS];
    logic [31:0] arrivals;

    t_result pending_results[$];
    int      error_count = 0;
    bit      no_idle;      // last part of the run: no idling on either side

    task automatic report_mismatch(input string what);
        $display("MISMATCH at %0t: %s", $realtime, what);
        error_count++;
    endtask

    // Best resting slot on one side: best price, then oldest stamp.
    function automatic int best_on_side(input logic s);
        int b;
        b = -1;
        for (int i = 0; i < SLOTS; i++) begin
            if (!bk_used[i] || bk_side[i] != s) continue;
            if (b < 0) b = i;
            else if (bk_price[i] != bk_price[b]) begin
                if (s == 1'b0 ? bk_price[i] > bk_price[b] : bk_price[i] < bk_price[b]) b = i;
            end else if (32'(arrivals - bk_stamp[i]) > 32'(arrivals - bk_stamp[b])) b = i;
        end
        return b;
    endfunction

    function automatic void fill_tops(inout t_result r);
        int b, a;
        b = best_on_side(1'b0);
        a = best_on_side(1'b1);
        r.best_bid    = (b >= 0) ? bk_price[b] : 8'd0;
        r.bid_present = (b >= 0);
        r.best_ask    = (a >= 0) ? bk_price[a] : 8'd0;
        r.ask_present = (a >= 0);
    endfunction

    function automatic t_result make_result(input logic [2:0] k, input logic [31:0] taker,
            input logic [31:0] maker, input logic [7:0] px, input logic [15:0] fq,
            input logic [15:0] lq);
        t_result r;
        r = '0;
        r.kind = k; r.taker_id = taker; r.maker_id = maker;
        r.trade_price = px; r.fill_qty = fq; r.left_qty = lq;
        fill_tops(r);
        return r;
    endfunction

    // Works out every result of one accepted command and queues them.
    function automatic void predict_matching(input t_order o);
        t_result     out[$];
        logic [15:0] qty;
        logic [15:0] tq;
        logic [7:0]  tp;
        int          m, hit, fr;
        qty = o.quantity;
        if (o.command == CMD_NONE) return;
        if (o.command == CMD_CANCEL) begin
            hit = -1;
            for (int i = 0; i < SLOTS; i++) begin
                if (!bk_used[i] || bk_id[i] != o.order_id) continue;
                if (hit < 0 || 32'(arrivals - bk_stamp[i]) > 32'(arrivals - bk_stamp[hit]))
                    hit = i;
            end
            if (hit >= 0) begin
                bk_used[hit] = 1'b0;
                out = {out, make_result(KIND_CANCEL_DONE, o.order_id, '0, '0, '0, '0)};
            end else
                out = {out, make_result(KIND_CANCEL_MISS, o.order_id, '0, '0, '0, '0)};
        end else begin
            out = {out, make_result(KIND_ACCEPTED, o.order_id, '0, '0, '0, qty)};
            while (qty > 0) begin
                m = best_on_side(~o.side);
                if (m < 0) break;
                if (o.command == CMD_LIMIT) begin
                    if (o.side == 1'b0 && bk_price[m] > o.price) break;
                    if (o.side == 1'b1 && bk_price[m] < o.price) break;
                    tp = o.price;
                end else tp = bk_price[m];
                tq = (qty < bk_qty[m]) ? qty : bk_qty[m];
                qty -= tq;
                bk_qty[m] -= tq;
                if (bk_qty[m] == 0) bk_used[m] = 1'b0;
                out = {out, make_result(bk_qty[m] == 0 ? KIND_FILL_DONE : KIND_FILL_PART,
                    o.order_id, bk_id[m], tp, tq, bk_qty[m])};
            end
            if (o.command == CMD_LIMIT && qty > 0) begin
                fr = -1;
                for (int i = 0; i < SLOTS; i++)
                    if (!bk_used[i] && fr < 0) fr = i;
                if (fr >= 0) begin
                    bk_used[fr] = 1'b1; bk_side[fr] = o.side; bk_price[fr] = o.price;
                    bk_id[fr] = o.order_id; bk_qty[fr] = qty; bk_stamp[fr] = arrivals;
                    arrivals++;
                    // The last result reports the book tops after the rest.
                    fill_tops(out[out.size()-1]);
                end else
                    out = {out, make_result(KIND_REST_DROP, o.order_id, '0, '0, '0, qty)};
            end
        end
        out[out.size()-1].last = 1'b1;
        pending_results = {pending_results, out};
    endfunction

    // ------------------------------------------------------------------
    // Result side: random stall bursts, and a check at every transfer.
    // ------------------------------------------------------------------
    int stall_left;

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_ch.ready <= 1'b0;
            stall_left    = 0;
        end else begin
            if (res_ch.valid && res_ch.ready) begin
                if (pending_results.size() == 0)
                    report_mismatch($sformatf("unexpected result %p", res_ch.data));
                else begin
                    t_result e;
                    e = pending_results[0];
                    pending_results.delete(0);
                    if (res_ch.data.kind        !== e.kind)        report_mismatch("kind");
                    if (res_ch.data.taker_id    !== e.taker_id)    report_mismatch("taker_id");
                    if (res_ch.data.maker_id    !== e.maker_id)    report_mismatch("maker_id");
                    if (res_ch.data.trade_price !== e.trade_price) report_mismatch("trade_price");
                    if (res_ch.data.fill_qty    !== e.fill_qty)    report_mismatch("fill_qty");
                    if (res_ch.data.left_qty    !== e.left_qty)    report_mismatch("left_qty");
                    if (res_ch.data.best_bid    !== e.best_bid)    report_mismatch("best_bid");
                    if (res_ch.data.bid_present !== e.bid_present) report_mismatch("bid_present");
                    if (res_ch.data.best_ask    !== e.best_ask)    report_mismatch("best_ask");
                    if (res_ch.data.ask_present !== e.ask_present) report_mismatch("ask_present");
                    if (res_ch.data.last        !== e.last)        report_mismatch("last");
                end
            end
            // Stalls come in bursts; ready rises again when a burst ends.
            if (stall_left > 0) begin
                stall_left--;
                res_ch.ready <= (stall_left == 0);
            end else if (!no_idle && $urandom_range(0, 9) == 0) begin
                stall_left    = $urandom_range(1, 17);
                res_ch.ready <= 1'b0;
            end else
                res_ch.ready <= 1'b1;
        end
    end

    // Watchdog: counts cycles without any transfer on either channel.
    int quiet_cycles = 0;
    always @(posedge i_clk) begin
        if ((ord_ch.valid && ord_ch.ready) || (res_ch.valid && res_ch.ready))
            quiet_cycles = 0;
        else if (++quiet_cycles >= WATCH_MAX) begin
            $display("tb_top: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Order side.
    // ------------------------------------------------------------------
    // Valid stays up after a transfer; the next call replaces the payload
    // or drops valid for a gap, and hold_orders drops it before a wait.
    task automatic send_order(input t_order o);
        int gap;
        if (!no_idle && $urandom_range(0, 7) == 0) begin
            gap = $urandom_range(1, 17);
            ord_ch.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        ord_ch.valid <= 1'b1;
        ord_ch.data  <= o;
        @(posedge i_clk);
        while (!ord_ch.ready) @(posedge i_clk);
        // Prediction runs in order of acceptance, so the model stays in step.
        predict_matching(o);
    endtask

    // Stops sending and waits until every predicted result has arrived.
    task automatic hold_orders();
        ord_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending_results.size() != 0) @(posedge i_clk);
    endtask

    function automatic t_order mk(input logic [1:0] c, input logic s, input logic [31:0] id,
            input logic [7:0] p, input logic [15:0] q);
        t_order o;
        o.command = c; o.side = s; o.order_id = id; o.price = p; o.quantity = q;
        return o;
    endfunction

    // Ids come from a small pool so that cancels and duplicates hit often.
    logic [31:0] id_pool[8];

    function automatic t_order random_order();
        t_order o;
        int r;
        r = $urandom_range(0, 99);
        o.side     = 1'($urandom_range(0, 1));
        o.order_id = ($urandom_range(0, 3) == 0) ? $urandom() : id_pool[$urandom_range(0, 7)];
        o.price    = ($urandom_range(0, 9) == 0) ? 8'($urandom()) : 8'($urandom_range(120, 136));
        o.quantity = ($urandom_range(0, 9) == 0) ? 16'($urandom()) : 16'($urandom_range(0, 40));
        if (r < 60)      o.command = CMD_LIMIT;
        else if (r < 75) o.command = CMD_MARKET;
        else if (r < 97) o.command = CMD_CANCEL;
        else             o.command = CMD_NONE;
        return o;
    endfunction

    // Directed rows: the first ones carry a hand-written first result.
    typedef struct {
        t_order  o;
        bit      has_exp;
        t_result e;
    } t_row;

    t_row rows[$];

    function automatic t_result er(input logic [2:0] k, input logic [31:0] t,
            input logic [15:0] lq, input logic l);
        t_result r;
        r = '0;
        r.kind = k; r.taker_id = t; r.left_qty = lq; r.last = l;
        return r;
    endfunction

    task automatic add_row(input t_order o, input bit h, input t_result e);
        t_row r;
        r.o = o; r.has_exp = h; r.e = e;
        rows = {rows, r};
    endtask

    initial begin
        t_result head;
        no_idle       = 1'b0;
        arrivals      = '0;
        foreach (bk_used[i]) bk_used[i] = 1'b0;
        foreach (id_pool[i]) id_pool[i] = (i == 0) ? 32'hFFFF_FFFF : 32'(i * 17);
        ord_ch.valid  = 1'b0;
        ord_ch.data   = '0;
        i_rst_n       = 1'b0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Empty book: cancel misses, market order trades nothing, unknown command, zero-quantity limit.
        add_row(mk(CMD_CANCEL, 1'b0, 32'hFFFF_FFFF, 8'd0, 16'd0), 1'b1,
                er(KIND_CANCEL_MISS, 32'hFFFF_FFFF, 16'd0, 1'b1));
        add_row(mk(CMD_MARKET, 1'b1, 32'd0, 8'd0, 16'hFFFF), 1'b1,
                er(KIND_ACCEPTED, 32'd0, 16'hFFFF, 1'b1));
        add_row(mk(CMD_NONE, 1'b1, 32'd5, 8'd9, 16'd9), 1'b0, '0);
        add_row(mk(CMD_LIMIT, 1'b0, 32'd1, 8'd0, 16'd0), 1'b1,
                er(KIND_ACCEPTED, 32'd1, 16'd0, 1'b1));
        // Extremes of price and quantity resting on both sides.
        add_row(mk(CMD_LIMIT, 1'b0, 32'd2, 8'd0, 16'd5), 1'b0, '0);
        add_row(mk(CMD_LIMIT, 1'b1, 32'd3, 8'd255, 16'hFFFF), 1'b0, '0);
        add_row(mk(CMD_LIMIT, 1'b0, 32'd4, 8'd100, 16'd10), 1'b0, '0);
        add_row(mk(CMD_LIMIT, 1'b0, 32'd4, 8'd100, 16'd7), 1'b0, '0);  // duplicate id
        add_row(mk(CMD_LIMIT, 1'b1, 32'd5, 8'd90, 16'd12), 1'b0, '0);  // crosses two buys
        add_row(mk(CMD_LIMIT, 1'b1, 32'd4, 8'd100, 16'd3), 1'b0, '0);  // self trade
        add_row(mk(CMD_MARKET, 1'b0, 32'd6, 8'd7, 16'd20), 1'b0, '0);
        add_row(mk(CMD_CANCEL, 1'b1, 32'd4, 8'd0, 16'd0), 1'b0, '0);
        add_row(mk(CMD_CANCEL, 1'b0, 32'd2, 8'd0, 16'd0), 1'b0, '0);
        add_row(mk(CMD_MARKET, 1'b1, 32'd7, 8'd0, 16'hFFFF), 1'b0, '0);
        foreach (rows[i]) begin
            if (rows[i].has_exp && pending_results.size() != 0)
                report_mismatch("directed row queued behind earlier results");
            send_order(rows[i].o);
            if (rows[i].has_exp && rows[i].o.command != CMD_NONE) begin
                head = pending_results[0];
                if (head.kind !== rows[i].e.kind || head.taker_id !== rows[i].e.taker_id ||
                    head.left_qty !== rows[i].e.left_qty || head.last !== rows[i].e.last)
                    report_mismatch("directed row disagrees with book model");
            end
            hold_orders();
        end

        // Fill the store to its limit so that a remainder must be dropped.
        for (int i = 0; i < SLOTS + 2; i++)
            send_order(mk(CMD_LIMIT, 1'b1, 32'(1000 + i), 8'(200 + i), 16'd1));
        // Sweep the small sells with one market buy: many fills from one order.
        send_order(mk(CMD_MARKET, 1'b0, 32'd77, 8'd0, 16'd40));
        // Hold off until every result is in.
        hold_orders();

        for (int n = 0; n < 170; n++) begin
            if (n == 140) no_idle = 1'b1;
            send_order(random_order());
        end

        hold_orders();
        repeat (200) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_top: done, clean");
        else
            $display("tb_top: done, errors");
        $finish;
    end
endmodule

// ===== sim.f =====
rtl/ptom_pkg.sv
rtl/ptom_chan.sv
rtl/ptom_dpath.sv
rtl/ptom_ctrl.sv
rtl/price_time_order_matcher_top.sv
tb/tb_top.sv
